/* rtl/lccf_pkg.sv */
// lccf_pkg: shared constants, types and the palette table of the led chase unit
// no dependencies; imported by every module of the block
`default_nettype none

package lccf_pkg;

    localparam int NUM_PIXELS   = 8;
    localparam int PALETTE_SIZE = 6;
    localparam int QUEUE_DEPTH  = 2;

    localparam int HEAD_W = $clog2(NUM_PIXELS);
    localparam int CIDX_W = $clog2(PALETTE_SIZE);

    localparam logic [HEAD_W-1:0] LAST_PIXEL = HEAD_W'(NUM_PIXELS - 1);
    localparam logic [CIDX_W-1:0] LAST_COLOR = CIDX_W'(PALETTE_SIZE - 1);

    // configuration register indexes
    localparam logic [1:0] REG_STEP_INTERVAL     = 2'd0;
    localparam logic [1:0] REG_SWITCH_LAPS       = 2'd1;
    localparam logic [1:0] REG_TRANSITION_FRAMES = 2'd2;

    localparam logic [15:0] STEP_INTERVAL_RST     = 16'd100;
    localparam logic [7:0]  SWITCH_LAPS_RST       = 8'd3;
    localparam logic [9:0]  TRANSITION_FRAMES_RST = 10'd20;

    localparam logic [23:0] COLOR_CYAN    = 24'h00FFFF;
    localparam logic [23:0] COLOR_MAGENTA = 24'hFF00FF;
    localparam logic [23:0] COLOR_YELLOW  = 24'hFFFF00;
    localparam logic [23:0] COLOR_GREEN   = 24'h008000;
    localparam logic [23:0] COLOR_BLUE    = 24'h0000FF;
    localparam logic [23:0] COLOR_RED     = 24'hFF0000;

    // one frame handed from the front to the pixel sequencer
    typedef struct packed {
        logic [23:0]       color;
        logic [HEAD_W-1:0] head;
    } frame_t;

    // six base colors, repeating for larger palettes
    function automatic logic [23:0] palette_color(input logic [3:0] idx);
        logic [23:0] c;
        case (idx) inside
            4'd0, 4'd6, 4'd12: c = COLOR_CYAN;
            4'd1, 4'd7, 4'd13: c = COLOR_MAGENTA;
            4'd2, 4'd8, 4'd14: c = COLOR_YELLOW;
            4'd3, 4'd9, 4'd15: c = COLOR_GREEN;
            4'd4, 4'd10:       c = COLOR_BLUE;
            4'd5, 4'd11:       c = COLOR_RED;
            default:           c = COLOR_CYAN;
        endcase
        return c;
    endfunction

    function automatic logic [CIDX_W-1:0] next_color_index(input logic [CIDX_W-1:0] idx);
        return (idx == LAST_COLOR) ? '0 : idx + CIDX_W'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/led_chase_color_crossfade_unit.sv */
// led_chase_color_crossfade_unit: top level of the led chase with palette crossfade
// depends on lccf_pkg, lccf_front, lccf_queue and lccf_back
`default_nettype none

// Each accepted frame request (now_ms, restart) yields NUM_PIXELS results, pixel 0 first,
// frame_end set on the last one. The front takes a request, then steps the head and decides
// the fade; during a crossfade it adds a shift-subtract divider for the blend ratio and the
// shared channel multiplier, used on each channel in turn. The pixel sequencer emits one
// result per cycle while out_stall is low, and loads each frame before its first result.
// A two-frame queue sits between them. Configuration writes are always ready and take
// effect at once.
module led_chase_color_crossfade_unit
    import lccf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] now_ms,
    input  wire logic        restart,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       pixel_index,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             frame_end
);

    logic   push_valid;
    logic   push_ready;
    frame_t push_frame;
    logic   q_valid;
    logic   q_pop;
    frame_t q_frame;

    lccf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_ms     (now_ms),
        .restart    (restart),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    lccf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_frame  (q_frame)
    );

    lccf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (q_valid),
        .frame_pop   (q_pop),
        .frame       (q_frame),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire

/* rtl/lccf_front.sv */
// lccf_front: frame request intake, config registers, chase/lap/fade state and color blend
// depends on lccf_pkg; pushes one frame_t per request toward the pixel sequencer
`default_nettype none

module lccf_front
    import lccf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] now_ms,
    input  wire logic        restart,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             push_valid,
    input  wire logic        push_ready,
    output frame_t           push_frame
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_FADE,
        S_DIV,
        S_MIX,
        S_PUSH
    } state_t;

    localparam int DIV_W = 18;
    localparam logic [4:0] DIV_LAST = 5'(DIV_W - 1);

    state_t            state_reg;
    logic [15:0]       step_interval_reg;
    logic [7:0]        switch_laps_reg;
    logic [9:0]        transition_frames_reg;

    logic [31:0]       now_reg;
    logic [HEAD_W-1:0] head_pos_reg;
    logic [31:0]       last_step_reg;
    logic [7:0]        lap_count_reg;
    logic [9:0]        fade_progress_reg;
    logic [CIDX_W-1:0] color_index_reg;
    logic [23:0]       current_color_reg;
    logic [23:0]       target_color_reg;
    logic [23:0]       color_reg;

    logic [DIV_W-1:0]  dvd_reg;
    logic [9:0]        rem_reg;
    logic [4:0]        div_cnt_reg;
    logic [1:0]        chan_reg;

    logic [31:0]       elapsed;
    logic              step_go;
    logic [7:0]        lap_inc;
    logic              fade_start;
    logic [10:0]       rem_shift;
    logic              rem_ge;
    logic [7:0]        chan_from;
    logic [7:0]        chan_to;
    logic signed [8:0] chan_diff;
    logic signed [17:0] chan_prod;
    logic signed [18:0] chan_sum;
    logic [4:0]        chan_lsb;

    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign push_valid = (state_reg == S_PUSH);
    assign push_frame = '{color: color_reg, head: head_pos_reg};

    always_comb
    begin
        elapsed    = now_reg - last_step_reg;
        step_go    = elapsed > {16'd0, step_interval_reg};
        lap_inc    = (lap_count_reg == 8'hFF) ? lap_count_reg : lap_count_reg + 8'd1;
        fade_start = (lap_inc >= switch_laps_reg) && (fade_progress_reg == 10'd0);

        rem_shift  = {rem_reg, dvd_reg[DIV_W-1]};
        rem_ge     = rem_shift >= {1'b0, transition_frames_reg};

        // from*(256-r) + to*r == from*256 + (to-from)*r
        chan_lsb   = {chan_reg, 3'b000};
        chan_from  = current_color_reg[chan_lsb +: 8];
        chan_to    = target_color_reg[chan_lsb +: 8];
        chan_diff  = signed'({1'b0, chan_to}) - signed'({1'b0, chan_from});
        chan_prod  = chan_diff * signed'({1'b0, dvd_reg[7:0]});
        chan_sum   = signed'({3'b000, chan_from, 8'h00}) + 19'(chan_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            step_interval_reg     <= STEP_INTERVAL_RST;
            switch_laps_reg       <= SWITCH_LAPS_RST;
            transition_frames_reg <= TRANSITION_FRAMES_RST;
            now_reg               <= '0;
            head_pos_reg          <= '0;
            last_step_reg         <= '0;
            lap_count_reg         <= '0;
            fade_progress_reg     <= '0;
            color_index_reg       <= '0;
            current_color_reg     <= COLOR_CYAN;
            target_color_reg      <= COLOR_MAGENTA;
            color_reg             <= '0;
            dvd_reg               <= '0;
            rem_reg               <= '0;
            div_cnt_reg           <= '0;
            chan_reg              <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_STEP_INTERVAL:     step_interval_reg     <= cfg_data[15:0];
                    REG_SWITCH_LAPS:       switch_laps_reg       <= cfg_data[7:0];
                    REG_TRANSITION_FRAMES: transition_frames_reg <= cfg_data[9:0];
                    default:               ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg <= now_ms;
                        if (restart)
                        begin
                            color_index_reg   <= '0;
                            current_color_reg <= palette_color(4'd0);
                            target_color_reg  <= palette_color(4'd1);
                            lap_count_reg     <= '0;
                            fade_progress_reg <= '0;
                        end
                        state_reg <= S_STEP;
                    end
                end

                S_STEP:
                begin
                    if (step_go)
                    begin
                        last_step_reg <= now_reg;
                        head_pos_reg  <= (head_pos_reg == LAST_PIXEL) ? '0
                                                                      : head_pos_reg + HEAD_W'(1);
                        if (head_pos_reg == LAST_PIXEL)
                        begin
                            if (fade_start)
                            begin
                                target_color_reg  <= palette_color(
                                    4'(next_color_index(color_index_reg)));
                                fade_progress_reg <= 10'd1;
                                lap_count_reg     <= '0;
                            end
                            else
                            begin
                                lap_count_reg <= lap_inc;
                            end
                        end
                    end
                    state_reg <= S_FADE;
                end

                S_FADE:
                begin
                    if (fade_progress_reg == 10'd0)
                    begin
                        color_reg <= current_color_reg;
                        state_reg <= S_PUSH;
                    end
                    else if (fade_progress_reg < transition_frames_reg)
                    begin
                        // ratio = progress*256 / frames
                        dvd_reg     <= {fade_progress_reg, 8'h00};
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        color_index_reg   <= next_color_index(color_index_reg);
                        current_color_reg <= target_color_reg;
                        color_reg         <= target_color_reg;
                        fade_progress_reg <= '0;
                        state_reg         <= S_PUSH;
                    end
                end

                S_DIV:
                begin
                    rem_reg <= rem_ge ? 10'(rem_shift - {1'b0, transition_frames_reg})
                                      : rem_shift[9:0];
                    dvd_reg <= {dvd_reg[DIV_W-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        chan_reg  <= '0;
                        state_reg <= S_MIX;
                    end
                end

                S_MIX:
                begin
                    color_reg[chan_lsb +: 8] <= chan_sum[15:8];
                    chan_reg <= chan_reg + 2'd1;
                    if (chan_reg == 2'd2)
                    begin
                        fade_progress_reg <= fade_progress_reg + 10'd1;
                        state_reg         <= S_PUSH;
                    end
                end

                S_PUSH:
                begin
                    if (push_ready)
                        state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/lccf_queue.sv */
// lccf_queue: short frame queue between the front and the pixel sequencer
// depends on lccf_pkg for frame_t and QUEUE_DEPTH
`default_nettype none

module lccf_queue
    import lccf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  frame_t    push_frame,
    output logic      pop_valid,
    input  wire logic pop,
    output frame_t    pop_frame
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    frame_t            entry_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_frame  = entry_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_mem[wr_ptr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/lccf_back.sv */
// lccf_back: pixel sequencer, expands one queued frame into one result per pixel
// depends on lccf_pkg; output register decouples it from the downstream stall
`default_nettype none

module lccf_back
    import lccf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   frame_valid,
    output logic        frame_pop,
    input  frame_t      frame,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic [2:0]  pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        frame_end
);

    logic              busy_reg;
    logic [HEAD_W-1:0] pix_reg;
    frame_t            frame_reg;
    logic              out_valid_reg;
    logic [2:0]        pixel_index_reg;
    logic [7:0]        red_reg;
    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;
    logic              frame_end_reg;

    logic              load;
    logic [HEAD_W:0]   trail_gap;
    logic              lit;
    logic [1:0]        shift;

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign frame_end   = frame_end_reg;

    assign load      = !out_valid_reg || !out_stall;
    assign frame_pop = !busy_reg && frame_valid;

    // trail sits behind the head and does not wrap past pixel 0
    always_comb
    begin
        trail_gap = {1'b0, frame_reg.head} - {1'b0, pix_reg};
        lit       = !trail_gap[HEAD_W] && (trail_gap < (HEAD_W+1)'(4));
        shift     = trail_gap[1:0];
    end

    always_ff @(posedge clk)
    begin
        if (frame_pop)
            frame_reg <= frame;
        if (busy_reg && load)
        begin
            pixel_index_reg <= 3'(pix_reg);
            red_reg         <= lit ? frame_reg.color[23:16] >> shift : 8'd0;
            green_reg       <= lit ? frame_reg.color[15:8] >> shift : 8'd0;
            blue_reg        <= lit ? frame_reg.color[7:0] >> shift : 8'd0;
            frame_end_reg   <= (pix_reg == LAST_PIXEL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_pop)
            begin
                busy_reg <= 1'b1;
                pix_reg  <= '0;
            end
            if (load)
                out_valid_reg <= busy_reg;
            if (busy_reg && load)
            begin
                if (pix_reg == LAST_PIXEL)
                    busy_reg <= 1'b0;
                else
                    pix_reg <= pix_reg + HEAD_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* tb/crossfade_checker.sv */
// crossfade_checker: watches the frame, config and pixel channels of the led chase unit,
// predicts every pixel of each frame and compares it against what the block emits
// depends on lccf_pkg for the register indexes, reset values and palette colors
`default_nettype none

module crossfade_checker
    import lccf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [31:0] now_ms,
    input  wire logic        restart,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  pixel_index,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic        frame_end,
    output int               fail_count,
    output int               pixels_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] index;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } pixel_t;

    pixel_t      pixel_fifo[$];
    int          mismatch_count = 0;

    // register copies
    logic [15:0] step_ms;
    logic [7:0]  laps_to_switch;
    logic [9:0]  fade_frames;

    // chase and palette state
    logic [2:0]  head;
    logic [31:0] last_step;
    logic [7:0]  laps;
    logic [9:0]  fade_pos;
    logic [2:0]  color_idx;
    logic [23:0] color_now;
    logic [23:0] color_next;

    assign fail_count = mismatch_count;

    function automatic logic [23:0] palette_entry(input int unsigned idx);
        case ((idx % PALETTE_SIZE) % 6)
            0:       return COLOR_CYAN;
            1:       return COLOR_MAGENTA;
            2:       return COLOR_YELLOW;
            3:       return COLOR_GREEN;
            4:       return COLOR_BLUE;
            default: return COLOR_RED;
        endcase
    endfunction

    function automatic logic [23:0] mix_colors(input logic [23:0] from_c,
                                               input logic [23:0] to_c,
                                               input logic [9:0]  t,
                                               input logic [9:0]  dur);
        int unsigned ratio;
        int unsigned a;
        int unsigned b;
        int unsigned sh;
        logic [23:0] mixed;
        ratio = (32'(t) * 32'd256) / 32'(dur);
        mixed = '0;
        for (sh = 0; sh < 24; sh += 8)
        begin
            a = from_c[sh +: 8];
            b = to_c[sh +: 8];
            mixed[sh +: 8] = 8'((a * (256 - ratio) + b * ratio) / 256);
        end
        return mixed;
    endfunction

    task automatic report(input string what);
        $display("%0t ns: pixel mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic restart_palette();
        color_idx  = '0;
        color_now  = palette_entry(0);
        color_next = palette_entry(1);
        laps       = '0;
        fade_pos   = '0;
    endtask

    task automatic predict_frame(input logic [31:0] stamp, input logic rs);
        logic [2:0]  prev;
        logic [23:0] shade;
        logic [31:0] elapsed;
        pixel_t      px;
        int          dim;
        if (rs)
            restart_palette();

        elapsed = stamp - last_step;
        if (elapsed > {16'd0, step_ms})
        begin
            prev      = head;
            head      = (head == 3'(NUM_PIXELS - 1)) ? 3'd0 : head + 3'd1;
            last_step = stamp;
            if (prev == 3'(NUM_PIXELS - 1))
            begin
                // lap counter saturates instead of wrapping
                if (laps != 8'hFF)
                    laps = laps + 8'd1;
                if (laps >= laps_to_switch && fade_pos == '0)
                begin
                    color_next = palette_entry((color_idx + 1) % PALETTE_SIZE);
                    fade_pos   = 10'd1;
                    laps       = '0;
                end
            end
        end

        shade = color_now;
        if (fade_pos != '0)
        begin
            if (fade_pos < fade_frames)
            begin
                shade    = mix_colors(color_now, color_next, fade_pos, fade_frames);
                fade_pos = fade_pos + 10'd1;
            end
            else
            begin
                // fade done, or its length was cut below the progress
                color_idx = 3'((color_idx + 1) % PALETTE_SIZE);
                color_now = color_next;
                fade_pos  = '0;
                shade     = color_now;
            end
        end

        for (int i = 0; i < NUM_PIXELS; i++)
        begin
            // trail sits behind the head and does not wrap past pixel 0
            dim = -1;
            if (i == int'(head))
                dim = 0;
            else if (i + 1 == int'(head))
                dim = 1;
            else if (i + 2 == int'(head))
                dim = 2;
            else if (i + 3 == int'(head))
                dim = 3;
            px.index = 3'(i);
            px.r     = (dim >= 0) ? shade[23:16] >> dim : 8'd0;
            px.g     = (dim >= 0) ? shade[15:8] >> dim : 8'd0;
            px.b     = (dim >= 0) ? shade[7:0] >> dim : 8'd0;
            px.last  = (i == NUM_PIXELS - 1);
            pixel_fifo.push_back(px);
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pixel_fifo.size() == 0)
        begin
            report($sformatf("pixel %0d arrived with no frame pending", pixel_index));
            return;
        end
        want = pixel_fifo.pop_front();
        if (pixel_index !== want.index)
            report($sformatf("pixel_index got %0d want %0d", pixel_index, want.index));
        if (red !== want.r)
            report($sformatf("pixel %0d red got %02h want %02h", want.index, red, want.r));
        if (green !== want.g)
            report($sformatf("pixel %0d green got %02h want %02h", want.index, green, want.g));
        if (blue !== want.b)
            report($sformatf("pixel %0d blue got %02h want %02h", want.index, blue, want.b));
        if (frame_end !== want.last)
            report($sformatf("pixel %0d frame_end got %0b want %0b", want.index, frame_end,
                             want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ms        = STEP_INTERVAL_RST;
            laps_to_switch = SWITCH_LAPS_RST;
            fade_frames    = TRANSITION_FRAMES_RST;
            head           = '0;
            last_step      = '0;
            restart_palette();
            pixel_fifo.delete();
            pixels_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STEP_INTERVAL:     step_ms        = cfg_data[15:0];
                    REG_SWITCH_LAPS:       laps_to_switch = cfg_data[7:0];
                    REG_TRANSITION_FRAMES: fade_frames    = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_frame(now_ms, restart);
            if (out_valid && !out_stall)
                check_pixel();
            pixels_owed <= pixel_fifo.size();
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench: drives frame requests and register writes into the led chase unit with random
// idling on both sides; depends on lccf_pkg, the unit's rtl and crossfade_checker
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lccf_pkg::*;

    localparam logic [1:0] REG_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         SETTLE_CYCLES = 100;
    localparam int         PHASE_ITEMS  = 50;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] now_ms;
    logic        restart;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        frame_end;

    int          fail_count;
    int          pixels_owed;

    bit          quiet = 1'b0;
    bit          hold_pending = 1'b0;
    logic [31:0] cfg_interval;

    always #10 clk = ~clk;

    led_chase_color_crossfade_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .now_ms      (now_ms),
        .restart     (restart),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_end   (frame_end)
    );

    crossfade_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .now_ms      (now_ms),
        .restart     (restart),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_end   (frame_end),
        .fail_count  (fail_count),
        .pixels_owed (pixels_owed)
    );

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        else if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_frame(input logic [31:0] stamp, input logic rs);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        now_ms   <= stamp;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = (quiet || $urandom_range(0, 1)) ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixels_owed != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // bits above each register's width carry junk on about half the writes
    task automatic apply_settings(input logic [31:0] interval, input logic [31:0] lap_goal,
                                  input logic [31:0] frames);
        logic [31:0] junk;
        junk = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(REG_STEP_INTERVAL, {junk[31:16], interval[15:0]});
        write_reg(REG_SWITCH_LAPS, {junk[31:8], lap_goal[7:0]});
        write_reg(REG_TRANSITION_FRAMES, {junk[31:10], frames[9:0]});
        cfg_interval = {16'd0, interval[15:0]};
    endtask

    // pixel side: random stall bursts, a long hold on request, none in quiet phases
    initial
    begin : pixel_sink
        int  run_len;
        logic stall_val;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall_val    = 1'b1;
                run_len      = HOLD_CYCLES;
            end
            else if (quiet)
            begin
                stall_val = 1'b0;
                run_len   = 1;
            end
            else
            begin
                stall_val = ($urandom_range(0, 2) == 0);
                run_len   = stall_val ? idle_len() : $urandom_range(1, 8);
            end
            repeat (run_len)
            begin
                @(negedge clk);
                out_stall <= stall_val;
            end
        end
    end

    initial
    begin : run_limit
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] stamp;
        logic        rs;
        int          roll;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        now_ms    = '0;
        restart   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_STEP_INTERVAL;
        cfg_data  = '0;
        cfg_interval = {16'd0, STEP_INTERVAL_RST};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: elapsed exactly at the interval, timestamp wrap, restart without step
        send_frame(32'd0, 1'b0);
        send_frame(32'd100, 1'b0);
        send_frame(32'd101, 1'b0);
        send_frame(32'hFFFF_FFFF, 1'b0);
        send_frame(32'd5, 1'b0);
        send_frame(32'd101, 1'b0);
        send_frame(32'd101, 1'b1);
        send_frame(32'h8000_0000, 1'b0);
        drain();

        // zero interval, one lap per fade, short fades, restart mid chase
        apply_settings(32'd0, 32'd1, 32'd3);
        for (int k = 1; k <= 16; k++)
            send_frame(32'h8000_0000 + k, k == 12);
        send_frame(32'h8000_0010, 1'b0);
        drain();

        stamp = 32'h8000_0010;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       apply_settings(32'd2, 32'd1, 32'd1023);
                1:       apply_settings(32'd0, 32'd0, 32'd0);
                2:       apply_settings(32'd65535, 32'd255, 32'd1023);
                3:       apply_settings(32'd1, 32'd1, 32'd4);
                default: apply_settings($urandom_range(0, 40), $urandom_range(0, 3),
                                        $urandom_range(0, 24));
            endcase
            if (phase == 4)
                write_reg(REG_UNUSED, $urandom);
            quiet = (phase == 3);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 0 && n == 6)
                    hold_pending = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    stamp = stamp + cfg_interval + 32'd1 + $urandom_range(0, 3);
                else if (roll < 85)
                    stamp = stamp + $urandom_range(0, cfg_interval);
                else if (roll < 93)
                    stamp = $urandom;
                else
                    stamp = stamp - $urandom_range(1, 1000);
                rs = ($urandom_range(0, 31) == 0);
                send_frame(stamp, rs);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pixels_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/lccf_pkg.sv
rtl/lccf_front.sv
rtl/lccf_queue.sv
rtl/lccf_back.sv
rtl/led_chase_color_crossfade_unit.sv
tb/crossfade_checker.sv
tb/testbench.sv
